[rtl/core/ctb_pkg.sv]
package ctb_pkg;

  // Wide signed carrier for Q4.28 products
  typedef logic signed [71:0] wide_t;

  typedef logic signed [34:0] diff_t;

  localparam wide_t Q_ONE       = 72'sd268435456;
  localparam wide_t Q_PI        = 72'sd843314857;
  localparam wide_t Q_INV_PI    = 72'sd85445659;
  localparam wide_t Q_REFL_BASE = 72'sd10737418;
  localparam wide_t Q_EPS       = 72'sd268;

  localparam logic [15:0] UNIT_MAX = 16'h8000;
  localparam logic [32:0] SPEC_LIM = 33'h1_0000_0000;

  // quotient bits resolved by the divider, one per stage
  localparam int DIV_BITS = 33;
  localparam int REM_W    = 64;

  // front -> divider
  typedef struct packed {
    logic signed [35:0] num;
    logic signed [34:0] den;
    diff_t              diff_r;
    diff_t              diff_g;
    diff_t              diff_b;
  } ctb_frac_t;

  // side data riding along the divider
  typedef struct packed {
    logic  neg;
    logic  ovf;
    diff_t diff_r;
    diff_t diff_g;
    diff_t diff_b;
  } ctb_side_t;

  // divider -> output stage
  typedef struct packed {
    logic        neg;
    logic [32:0] mag;
    diff_t       diff_r;
    diff_t       diff_g;
    diff_t       diff_b;
  } ctb_spec_t;

endpackage

[rtl/core/ctb_in_if.sv]
interface ctb_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cos_in;
  logic signed [15:0] cos_out;
  logic [15:0]        albedo_red;
  logic [15:0]        albedo_green;
  logic [15:0]        albedo_blue;
  logic [15:0]        metalness;
  logic [15:0]        roughness;

  modport source (
    output valid, cos_in, cos_out, albedo_red, albedo_green, albedo_blue, metalness, roughness,
    input  ready
  );
  modport sink (
    input  valid, cos_in, cos_out, albedo_red, albedo_green, albedo_blue, metalness, roughness,
    output ready
  );
endinterface

[rtl/core/ctb_out_if.sv]
interface ctb_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] brdf_red;
  logic signed [16:0] brdf_green;
  logic signed [16:0] brdf_blue;

  modport source (output valid, brdf_red, brdf_green, brdf_blue, input ready);
  modport sink (input valid, brdf_red, brdf_green, brdf_blue, output ready);
endinterface

[rtl/core/ctb_front.sv]
module ctb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  ctb_in_if.sink            sample,
  output logic              out_valid,
  output ctb_pkg::ctb_frac_t out_frac
);
  import ctb_pkg::*;

  // signed product scaled by 2^-28, truncated toward zero
  function automatic wide_t qm(input wide_t a, input wide_t b);
    wide_t p;
    p = a * b;
    if (p < 0) p = p + (Q_ONE - 72'sd1);
    return p >>> 28;
  endfunction

  function automatic logic [15:0] unit_clip(input logic [15:0] v);
    return (v > UNIT_MAX) ? UNIT_MAX : v;
  endfunction

  logic [7:0] vld;

  logic [15:0]        rg_c, met_c, alb_r_c, alb_g_c, alb_b_c;
  logic signed [29:0] ci28_c, co28_c;
  wide_t              rp1_c;

  assign rg_c    = unit_clip(sample.roughness);
  assign met_c   = unit_clip(sample.metalness);
  assign alb_r_c = unit_clip(sample.albedo_red);
  assign alb_g_c = unit_clip(sample.albedo_green);
  assign alb_b_c = unit_clip(sample.albedo_blue);
  assign ci28_c  = {sample.cos_in[15], sample.cos_in, 13'd0};
  assign co28_c  = {sample.cos_out[15], sample.cos_out, 13'd0};
  assign rp1_c   = wide_t'({rg_c, 13'd0}) + Q_ONE;

  // stage 1
  logic signed [29:0] s1_ci28, s1_co28;
  logic [28:0]        s1_met28, s1_rough2, s1_csq, s1_refl0;
  logic signed [31:0] s1_cico;
  logic [29:0]        s1_om;
  logic [26:0]        s1_lam_r, s1_lam_g, s1_lam_b;
  logic [27:0]        s1_gk;
  // stage 2
  logic signed [29:0] s2_ci28, s2_co28;
  logic [28:0]        s2_met28, s2_rough4, s2_csq, s2_refl0, s2_omgk;
  logic signed [31:0] s2_cico;
  logic [29:0]        s2_om;
  logic [30:0]        s2_p2;
  logic [26:0]        s2_lam_r, s2_lam_g, s2_lam_b;
  logic [27:0]        s2_gk;
  // stage 3
  logic signed [29:0] s3_co28, s3_g1, s3_g2, s3_num1;
  logic [28:0]        s3_met28, s3_refl0, s3_dd;
  logic signed [31:0] s3_cico;
  logic [29:0]        s3_om;
  logic [31:0]        s3_p3;
  logic [26:0]        s3_lam_r, s3_lam_g, s3_lam_b;
  // stage 4
  logic signed [29:0] s4_g1, s4_g2, s4_num2;
  logic [28:0]        s4_met28, s4_refl0, s4_dd2;
  logic signed [31:0] s4_cico;
  logic [29:0]        s4_om;
  logic [32:0]        s4_p4;
  logic [26:0]        s4_lam_r, s4_lam_g, s4_lam_b;
  // stage 5
  logic signed [29:0] s5_g1, s5_g2, s5_num2;
  logic [28:0]        s5_met28, s5_refl0;
  logic [29:0]        s5_pdd;
  logic signed [31:0] s5_cico;
  logic [33:0]        s5_p5;
  logic [26:0]        s5_lam_r, s5_lam_g, s5_lam_b;
  // stage 6
  logic signed [29:0] s6_g2, s6_num2;
  logic [28:0]        s6_met28;
  logic [33:0]        s6_fres;
  logic signed [31:0] s6_den1, s6_cico;
  logic [26:0]        s6_lam_r, s6_lam_g, s6_lam_b;
  // stage 7
  logic signed [35:0] s7_num3, s7_dscale;
  logic signed [31:0] s7_den2, s7_cico;
  logic [26:0]        s7_lam_r, s7_lam_g, s7_lam_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:0], sample.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ci28   <= ci28_c;
      s1_co28   <= co28_c;
      s1_met28  <= {met_c, 13'd0};
      s1_rough2 <= 29'((32'(rg_c) * 32'(rg_c)) >> 2);
      s1_csq    <= 29'((wide_t'(sample.cos_in) * wide_t'(sample.cos_in)) >>> 2);
      s1_cico   <= 32'(wide_t'(sample.cos_in) * wide_t'(sample.cos_out));
      s1_om     <= 30'(Q_ONE - wide_t'(ci28_c));
      s1_lam_r  <= 27'(qm(wide_t'({alb_r_c, 13'd0}), Q_INV_PI));
      s1_lam_g  <= 27'(qm(wide_t'({alb_g_c, 13'd0}), Q_INV_PI));
      s1_lam_b  <= 27'(qm(wide_t'({alb_b_c, 13'd0}), Q_INV_PI));
      s1_refl0  <= 29'(Q_REFL_BASE + qm(Q_ONE - Q_REFL_BASE, wide_t'({met_c, 13'd0})));
      s1_gk     <= 28'(qm(rp1_c, rp1_c) >>> 3);

      s2_ci28   <= s1_ci28;
      s2_co28   <= s1_co28;
      s2_met28  <= s1_met28;
      s2_rough4 <= 29'(qm(wide_t'(s1_rough2), wide_t'(s1_rough2)));
      s2_csq    <= s1_csq;
      s2_refl0  <= s1_refl0;
      s2_omgk   <= 29'(Q_ONE - wide_t'(s1_gk));
      s2_cico   <= s1_cico;
      s2_om     <= s1_om;
      s2_p2     <= 31'(qm(wide_t'(s1_om), wide_t'(s1_om)));
      s2_lam_r  <= s1_lam_r;
      s2_lam_g  <= s1_lam_g;
      s2_lam_b  <= s1_lam_b;
      s2_gk     <= s1_gk;

      s3_co28   <= s2_co28;
      s3_g1     <= 30'(qm(wide_t'(s2_ci28), wide_t'(s2_omgk)) + wide_t'(s2_gk));
      s3_g2     <= 30'(qm(wide_t'(s2_co28), wide_t'(s2_omgk)) + wide_t'(s2_gk));
      s3_num1   <= 30'(qm(wide_t'(s2_rough4), wide_t'(s2_ci28)));
      s3_met28  <= s2_met28;
      s3_refl0  <= s2_refl0;
      s3_dd     <= 29'(qm(wide_t'(s2_csq), wide_t'(s2_rough4) - Q_ONE) + Q_ONE);
      s3_cico   <= s2_cico;
      s3_om     <= s2_om;
      s3_p3     <= 32'(qm(wide_t'(s2_p2), wide_t'(s2_om)));
      s3_lam_r  <= s2_lam_r;
      s3_lam_g  <= s2_lam_g;
      s3_lam_b  <= s2_lam_b;

      s4_g1     <= s3_g1;
      s4_g2     <= s3_g2;
      s4_num2   <= 30'(qm(wide_t'(s3_num1), wide_t'(s3_co28)));
      s4_met28  <= s3_met28;
      s4_refl0  <= s3_refl0;
      s4_dd2    <= 29'(qm(wide_t'(s3_dd), wide_t'(s3_dd)));
      s4_cico   <= s3_cico;
      s4_om     <= s3_om;
      s4_p4     <= 33'(qm(wide_t'(s3_p3), wide_t'(s3_om)));
      s4_lam_r  <= s3_lam_r;
      s4_lam_g  <= s3_lam_g;
      s4_lam_b  <= s3_lam_b;

      s5_g1     <= s4_g1;
      s5_g2     <= s4_g2;
      s5_num2   <= s4_num2;
      s5_met28  <= s4_met28;
      s5_refl0  <= s4_refl0;
      s5_pdd    <= 30'(qm(wide_t'(s4_dd2), Q_PI));
      s5_cico   <= s4_cico;
      s5_p5     <= 34'(qm(wide_t'(s4_p4), wide_t'(s4_om)));
      s5_lam_r  <= s4_lam_r;
      s5_lam_g  <= s4_lam_g;
      s5_lam_b  <= s4_lam_b;

      s6_g2     <= s5_g2;
      s6_num2   <= s5_num2;
      s6_met28  <= s5_met28;
      s6_fres   <= 34'(wide_t'(s5_refl0)
                   + qm(Q_ONE - wide_t'(s5_refl0), wide_t'(s5_p5)));
      s6_den1   <= 32'(qm(wide_t'(s5_pdd), wide_t'(s5_g1)));
      s6_cico   <= s5_cico;
      s6_lam_r  <= s5_lam_r;
      s6_lam_g  <= s5_lam_g;
      s6_lam_b  <= s5_lam_b;

      s7_num3   <= 36'(qm(wide_t'(s6_num2), wide_t'(s6_fres)));
      s7_den2   <= 32'(qm(wide_t'(s6_den1), wide_t'(s6_g2)));
      s7_dscale <= 36'(qm(Q_ONE - wide_t'(s6_fres), Q_ONE - wide_t'(s6_met28)));
      s7_cico   <= s6_cico;
      s7_lam_r  <= s6_lam_r;
      s7_lam_g  <= s6_lam_g;
      s7_lam_b  <= s6_lam_b;

      out_frac.num    <= s7_num3;
      out_frac.den    <= 35'(qm(wide_t'(s7_den2), wide_t'(s7_cico) + Q_EPS));
      out_frac.diff_r <= 35'(qm(wide_t'(s7_dscale), wide_t'(s7_lam_r)));
      out_frac.diff_g <= 35'(qm(wide_t'(s7_dscale), wide_t'(s7_lam_g)));
      out_frac.diff_b <= 35'(qm(wide_t'(s7_dscale), wide_t'(s7_lam_b)));
    end
  end

  assign out_valid = vld[7];

endmodule

[rtl/core/ctb_div.sv]
module ctb_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  ctb_pkg::ctb_frac_t frac,
  output logic               out_valid,
  output ctb_pkg::ctb_spec_t spec
);
  import ctb_pkg::*;

  logic signed [35:0] num_s;
  logic signed [34:0] den_s;
  logic [35:0]        a0;
  logic [34:0]        d0;
  logic               ovf0;

  assign num_s = frac.num;
  assign den_s = frac.den;
  assign a0    = (num_s < 0) ? 36'(-num_s) : 36'(num_s);
  assign d0    = (den_s < 0) ? 35'(-den_s) : 35'(den_s);
  // quotient >= 2^33 (or zero divisor) saturates outright
  assign ovf0  = (d0 == '0) || ((a0 >> 5) >= 36'(d0));

  logic [DIV_BITS:0]   vld;
  logic [REM_W-1:0]    rem  [DIV_BITS];
  logic [34:0]         dvs  [DIV_BITS];
  logic [DIV_BITS-1:0] quo  [DIV_BITS+1];
  ctb_side_t           side [DIV_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_BITS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]         <= {a0, 28'd0};
      dvs[0]         <= d0;
      quo[0]         <= '0;
      side[0].neg    <= (num_s < 0) ^ (den_s < 0);
      side[0].ovf    <= ovf0;
      side[0].diff_r <= frac.diff_r;
      side[0].diff_g <= frac.diff_g;
      side[0].diff_b <= frac.diff_b;
    end
  end

  // one restoring step per stage, MSB first
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
    localparam int SH = DIV_BITS - 1 - k;
    logic             take;

    assign take = (rem[k] >> SH) >= REM_W'(dvs[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        quo[k+1]  <= {quo[k][DIV_BITS-2:0], take};
        side[k+1] <= side[k];
      end
    end

    if (k < DIV_BITS - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= take ? rem[k] - (REM_W'(dvs[k]) << SH) : rem[k];
          dvs[k+1] <= dvs[k];
        end
      end
    end
  end

  assign out_valid   = vld[DIV_BITS];
  assign spec.neg    = side[DIV_BITS].neg;
  assign spec.mag    = (side[DIV_BITS].ovf || quo[DIV_BITS] > SPEC_LIM) ? SPEC_LIM
                                                                        : quo[DIV_BITS];
  assign spec.diff_r = side[DIV_BITS].diff_r;
  assign spec.diff_g = side[DIV_BITS].diff_g;
  assign spec.diff_b = side[DIV_BITS].diff_b;

endmodule

[rtl/core/ctb_back.sv]
module ctb_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  ctb_pkg::ctb_spec_t spec,
  ctb_out_if.source          result
);
  import ctb_pkg::*;

  function automatic logic signed [16:0] finish(input logic signed [34:0] d,
                                                input logic signed [33:0] s);
    logic signed [35:0] v;
    v = 36'(d) + 36'(s);
    if (v > 36'sd268435456) v = 36'sd268435456;
    if (v < -36'sd268435456) v = -36'sd268435456;
    if (v < 0) v = v + 36'sd8191;
    return 17'(v >>> 13);
  endfunction

  logic signed [33:0] spec_s;

  assign spec_s = spec.neg ? -$signed({1'b0, spec.mag}) : $signed({1'b0, spec.mag});

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.brdf_red   <= finish(spec.diff_r, spec_s);
      result.brdf_green <= finish(spec.diff_g, spec_s);
      result.brdf_blue  <= finish(spec.diff_b, spec_s);
    end
  end

endmodule

[rtl/core/cook_torrance_brdf_eval.sv]
// channel   dir  beat payload
// sample    in   cos_in, cos_out, albedo_red/green/blue, metalness, roughness
// result    out  brdf_red, brdf_green, brdf_blue
//
// One beat per cycle in and out while result is not held. The pipe has 43
// register stages: 8 multiply stages, 34 divider stages (an entry register, then
// one quotient bit in each of 33 steps) and the output register. The whole pipe
// advances together; when result is held, sample is held too. Synchronous reset
// clears all valid bits.
module cook_torrance_brdf_eval (
  input  logic      clk,
  input  logic      rst,
  ctb_in_if.sink    sample,
  ctb_out_if.source result
);
  import ctb_pkg::*;

  logic      en;
  logic      frac_valid;
  ctb_frac_t frac;
  logic      spec_valid;
  ctb_spec_t spec;

  assign en           = !result.valid || result.ready;
  assign sample.ready = en;

  ctb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .sample    (sample),
    .out_valid (frac_valid),
    .out_frac  (frac)
  );

  ctb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (frac_valid),
    .frac      (frac),
    .out_valid (spec_valid),
    .spec      (spec)
  );

  ctb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (spec_valid),
    .spec     (spec),
    .result   (result)
  );

  a_range_red: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.brdf_red >= -17'sd32768 && result.brdf_red <= 17'sd32768))
    else $error("brdf_red out of range");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !sample.ready)
    else $error("input taken while output stalled");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

  a_spec_sat: assert property (@(posedge clk) disable iff (rst)
    spec_valid |-> spec.mag <= SPEC_LIM)
    else $error("specular magnitude beyond limit");

endmodule

[sim/tb_brdf_score.sv]
// Scoreboard: predicts the BRDF sample of each accepted beat and checks results in order.
class brdf_score;
  logic signed [16:0] exp_r[$];
  logic signed [16:0] exp_g[$];
  logic signed [16:0] exp_b[$];
  int errors;
  int checked;

  function new();
    errors = 0;
    checked = 0;
  endfunction

  static function longint mulq(longint a, longint b);
    return (a * b) / 64'sd268435456;
  endfunction

  static function longint clip_unit(logic [15:0] v);
    return (v > 16'h8000) ? 64'sd32768 : longint'({48'd0, v});
  endfunction

  static function longint geo_term(longint c, longint gk);
    return mulq(c, 64'sd268435456 - gk) + gk;
  endfunction

  function void note_sample(logic signed [15:0] ci_in, logic signed [15:0] co_in,
                            logic [15:0] ar, logic [15:0] ag, logic [15:0] ab,
                            logic [15:0] mt, logic [15:0] rf);
    longint one, ci, co, ci28, co28, met, rg, r2, r4, csq, dd, pdd;
    longint f0, om, p5, fres, rp1, gk, num, den, spec, dsc, lam, v, lim;
    longint alb[3];
    logic signed [16:0] res[3];
    one = 64'sd268435456;
    lim = 64'sd4294967296;
    ci = ci_in;
    co = co_in;
    ci28 = ci * 8192;
    co28 = co * 8192;
    met = clip_unit(mt) * 8192;
    rg = clip_unit(rf);
    alb[0] = clip_unit(ar);
    alb[1] = clip_unit(ag);
    alb[2] = clip_unit(ab);
    r2 = (rg * rg) / 4;
    r4 = mulq(r2, r2);
    csq = (ci * ci) / 4;
    dd = mulq(csq, r4 - one) + one;
    pdd = mulq(mulq(dd, dd), 64'sd843314857);
    f0 = 64'sd10737418 + mulq(one - 64'sd10737418, met);
    om = one - ci28;
    p5 = mulq(om, om);
    p5 = mulq(p5, om);
    p5 = mulq(p5, om);
    p5 = mulq(p5, om);
    fres = f0 + mulq(one - f0, p5);
    rp1 = rg * 8192 + one;
    gk = mulq(rp1, rp1) / 8;
    num = mulq(mulq(mulq(r4, ci28), co28), fres);
    den = mulq(pdd, geo_term(ci28, gk));
    den = mulq(den, geo_term(co28, gk));
    den = mulq(den, ci * co + 268);
    if (den == 0) begin
      spec = (num < 0) ? -lim : lim;
    end else begin
      spec = (num * one) / den;
      if (spec > lim) spec = lim;
      if (spec < -lim) spec = -lim;
    end
    dsc = mulq(one - fres, one - met);
    for (int ch = 0; ch < 3; ch++) begin
      lam = mulq(alb[ch] * 8192, 64'sd85445659);
      v = mulq(dsc, lam) + spec;
      if (v > one) v = one;
      if (v < -one) v = -one;
      res[ch] = 17'(v / 8192);
    end
    exp_r.push_back(res[0]);
    exp_g.push_back(res[1]);
    exp_b.push_back(res[2]);
  endfunction

  function void check_result(logic signed [16:0] r, logic signed [16:0] g,
                             logic signed [16:0] b);
    logic signed [16:0] er, eg, eb;
    if (exp_r.size() == 0) begin
      $display("%0t: result beat with nothing expected (%0d %0d %0d)", $time, r, g, b);
      errors++;
      return;
    end
    er = exp_r.pop_front();
    eg = exp_g.pop_front();
    eb = exp_b.pop_front();
    checked++;
    if (r !== er) begin
      $display("%0t: brdf_red expected %0d got %0d", $time, er, r);
      errors++;
    end
    if (g !== eg) begin
      $display("%0t: brdf_green expected %0d got %0d", $time, eg, g);
      errors++;
    end
    if (b !== eb) begin
      $display("%0t: brdf_blue expected %0d got %0d", $time, eb, b);
      errors++;
    end
  endfunction

  function int pending();
    return exp_r.size();
  endfunction
endclass

[sim/tb.sv]
module tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic stim_done = 1'b0;
  int idle_cycles = 0;
  int sent = 0;
  bit timed_out = 1'b0;

  ctb_in_if  sample();
  ctb_out_if result();

  brdf_score board = new();

  cook_torrance_brdf_eval uut (.clk(clk), .rst(rst), .sample(sample), .result(result));

  always #10 clk = ~clk;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    sample.valid = 1'b0;
    sample.cos_in = '0;
    sample.cos_out = '0;
    sample.albedo_red = '0;
    sample.albedo_green = '0;
    sample.albedo_blue = '0;
    sample.metalness = '0;
    sample.roughness = '0;
    result.ready = 1'b0;
  end

  // accept side: note inputs, check results, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (sample.valid && sample.ready) begin
        board.note_sample(sample.cos_in, sample.cos_out, sample.albedo_red,
                          sample.albedo_green, sample.albedo_blue,
                          sample.metalness, sample.roughness);
        sent++;
      end
      if (result.valid && result.ready)
        board.check_result(result.brdf_red, result.brdf_green, result.brdf_blue);
      if ((sample.valid && sample.ready) || (result.valid && result.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > 3000) begin
        timed_out = 1'b1;
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // sink: random stalls, some long; clean stretches in between
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      result.ready <= 1'b1;
      n = $urandom_range(1, 40);
      repeat (n) @(negedge clk);
      n = gap_len();
      if (n > 0) begin
        result.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  task automatic send_beat(logic [15:0] ci, logic [15:0] co, logic [15:0] ar,
                           logic [15:0] ag, logic [15:0] ab, logic [15:0] mt,
                           logic [15:0] rf, bit hold_gap);
    int n;
    n = hold_gap ? gap_len() : 0;
    if (n > 0) begin
      sample.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    sample.valid <= 1'b1;
    sample.cos_in <= ci;
    sample.cos_out <= co;
    sample.albedo_red <= ar;
    sample.albedo_green <= ag;
    sample.albedo_blue <= ab;
    sample.metalness <= mt;
    sample.roughness <= rf;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_unit();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'($urandom());
    if (p == 1) return 16'h8000;
    if (p == 2) return 16'h0000;
    return 16'($urandom_range(0, 32768));
  endfunction

  function automatic logic [15:0] rand_cos();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'h8000;
    if (p == 1) return 16'h7fff;
    if (p == 2) return 16'h0000;
    if (p < 8) return 16'($urandom_range(0, 32767));
    return 16'($urandom());
  endfunction

  initial begin
    logic [15:0] ext[6];
    ext = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h4000};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // corners: cosine extremes, zero denominator, clamp of wide units
    foreach (ext[i]) begin
      send_beat(ext[i], ext[(i + 1) % 6], 16'h8000, 16'h0000, 16'hffff,
                16'h0000, 16'h8000, 1'b0);
      send_beat(ext[i], ext[i], 16'h4000, 16'h1234, 16'h7fff,
                16'h8000, 16'h0000, 1'b0);
    end
    send_beat(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h4000, 1'b0);
    send_beat(16'h4000, 16'hc000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h8000, 1'b0);
    send_beat(16'h0100, 16'h0100, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0);
    send_beat(16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0001, 1'b0);

    // hold off until the pipe drains
    sample.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);

    for (int k = 0; k < 1050; k++) begin
      send_beat(rand_cos(), rand_cos(), rand_unit(), rand_unit(), rand_unit(),
                rand_unit(), rand_unit(), (k % 200) > 60);
      if (k == 500) begin
        sample.valid <= 1'b0;
        while (board.pending() != 0) @(negedge clk);
      end
    end
    sample.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int guard;
    wait (stim_done);
    guard = 0;
    while (board.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
    $display("tb: %0d sample beats sent, %0d results checked", sent, board.checked);
    $display("tb: covered cosine extremes, zero denominators, over-range units, stalls");
    if (board.errors == 0 && board.pending() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end
endmodule
